/* src/sort_merge_key_counts_core_macros.svh */
// Assertion macros shared by the sort/merge key count RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef SORT_MERGE_KEY_COUNTS_CORE_MACROS_SVH
`define SORT_MERGE_KEY_COUNTS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMKC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/smkc_pkg.sv */
// Shared types and constants for the sort/merge key count block.
// No dependencies; imported by smkc_cell and sort_merge_key_counts_core.
`default_nettype none

package smkc_pkg;

  // Fixed port field widths.
  localparam int KEY_W       = 64;
  localparam int COUNT_W     = 8;

  // Storage sizing.
  localparam int CAPACITY    = 64;
  localparam int KEY_BITS    = 64;
  localparam int COUNT_BITS  = 8;

  // Saturation ceiling of a stored count.
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Input beat.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               batch_end;
  } smkc_in_t;

  // Result beat.
  typedef struct packed {
    logic [KEY_W-1:0]   out_key;
    logic [COUNT_W-1:0] out_count;
    logic               final_entry;
    logic               overflow;
  } smkc_out_t;

  // Contents of one cell of the sorted chain.
  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } smkc_entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                  merge;  // an input beat is being merged this cycle
    logic                  hit;    // some cell already holds the key
    logic                  full;   // the last cell is occupied
    logic                  emit;   // shift toward cell 0 to stream results
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } smkc_ctrl_t;

endpackage

`default_nettype wire

/* src/sort_merge_key_counts_core.sv */
// Top level of the sort/merge key count block: cell chain plus result sequencer.
// Depends on smkc_pkg, smkc_cell and sort_merge_key_counts_core_macros.svh.
//
// Usage:
//   An input beat (key, count, batch_end) is accepted on a rising edge with
//   start high and busy low. Each beat is compared against a sorted chain of
//   CAPACITY cells in the same cycle: a stored key gains the count with
//   saturation, a new key is inserted in order, and a new key that finds the
//   chain full is dropped and sets the overflow flag. Without batch_end a
//   beat yields nothing; beats may follow back to back. On the beat that
//   carries batch_end, busy rises in the next cycle and the chain drains
//   toward cell 0, one result beat per cycle on strobe, in ascending key
//   order, one result per stored key (1 to CAPACITY keys). The last result
//   carries final_entry; every result of the batch carries the batch's
//   overflow flag. Busy falls after the last result. The receiver cannot
//   stall: each result is present for exactly one cycle. Synchronous reset
//   empties the chain and clears overflow and busy.
`default_nettype none
`include "sort_merge_key_counts_core_macros.svh"

module sort_merge_key_counts_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  smkc_pkg::smkc_in_t  item,
  output logic               strobe,
  output smkc_pkg::smkc_out_t result
);
  import smkc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                state;
  logic                state_next;
  logic                dropped;
  logic                dropped_next;
  logic                accept;
  logic                last_out;
  smkc_ctrl_t          ctrl;
  smkc_entry_t         ent       [CAPACITY];
  smkc_entry_t         left_ent  [CAPACITY];
  smkc_entry_t         right_ent [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] left_lt;

  assign busy   = (state == ST_EMIT);
  assign accept = start && !busy;

  // Broadcast control for the chain.
  always_comb begin
    ctrl.merge = accept;
    ctrl.hit   = |eq_vec;
    ctrl.full  = ent[CAPACITY-1].valid;
    ctrl.emit  = busy;
    ctrl.key   = KEY_BITS'(item.key);
    ctrl.count = COUNT_BITS'(item.count);
  end

  // The chain of cells with neighbor links; the ends see fixed boundaries.
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign left_ent[gi] = '0;
        assign left_lt[gi]  = 1'b1;
      end else begin : g_body
        assign left_ent[gi] = ent[gi-1];
        assign left_lt[gi]  = lt_vec[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign right_ent[gi] = '0;
      end else begin : g_inner
        assign right_ent[gi] = ent[gi+1];
      end

      smkc_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_entry  (left_ent[gi]),
        .left_lt     (left_lt[gi]),
        .right_entry (right_ent[gi]),
        .entry       (ent[gi]),
        .lt          (lt_vec[gi]),
        .eq          (eq_vec[gi])
      );
    end
  endgenerate

  // Result beat comes straight from the registered head cell.
  assign last_out = !ent[1].valid;
  assign strobe   = busy;
  always_comb begin
    result.out_key     = KEY_W'(ent[0].key);
    result.out_count   = COUNT_W'(ent[0].count);
    result.final_entry = last_out;
    result.overflow    = dropped;
  end

  // Sequencer and overflow flag.
  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (ctrl.full && !ctrl.hit) begin
            dropped_next = 1'b1;
          end
          if (item.batch_end) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (last_out) begin
          state_next   = ST_IDLE;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  // Checks on the sequencer and chain.
  `SMKC_ASSERT_NEXT(a_end_starts_emit, clk, rst, accept && item.batch_end, strobe, "batch end did not start results")
  `SMKC_ASSERT_NOW(a_head_valid, clk, rst, strobe, ent[0].valid, "result beat from an empty head cell")
  `SMKC_ASSERT_NEXT(a_emit_continues, clk, rst, strobe && !result.final_entry, strobe, "results stopped before final entry")
  `SMKC_ASSERT_NEXT(a_final_idle, clk, rst, strobe && result.final_entry, !busy && !ent[0].valid && !dropped, "chain not empty after final entry")

endmodule

`default_nettype wire

/* src/smkc_cell.sv */
// One cell of the sorted key chain: compares, merges and shifts one entry.
// Depends on smkc_pkg for the entry and control types.
`default_nettype none

module smkc_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  smkc_pkg::smkc_ctrl_t  ctrl,
  input  smkc_pkg::smkc_entry_t left_entry,
  input  wire                  left_lt,
  input  smkc_pkg::smkc_entry_t right_entry,
  output smkc_pkg::smkc_entry_t entry,
  output logic                 lt,
  output logic                 eq
);
  import smkc_pkg::*;

  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat_count;
  smkc_entry_t           entry_next;

  // Compare the stored key with the broadcast key.
  assign lt = entry.valid && (entry.key < ctrl.key);
  assign eq = entry.valid && (entry.key == ctrl.key);

  // Saturating add of the incoming count.
  assign sum       = {1'b0, entry.count} + {1'b0, ctrl.count};
  assign sat_count = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];

  // Next contents: merge in place, insert or open a slot by shifting right, or drain left.
  always_comb begin
    entry_next = entry;
    if (ctrl.emit) begin
      entry_next = right_entry;
    end else if (ctrl.merge) begin
      if (ctrl.hit) begin
        if (eq) begin
          entry_next.count = sat_count;
        end
      end else if (!ctrl.full && !lt) begin
        if (left_lt) begin
          entry_next.valid = 1'b1;
          entry_next.key   = ctrl.key;
          entry_next.count = ctrl.count;
        end else begin
          entry_next = left_entry;
        end
      end
    end
  end

  // Valid is control state; key and count need no reset.
  always_ff @(posedge clk) begin
    entry.key   <= entry_next.key;
    entry.count <= entry_next.count;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_sort_merge_key_counts_core.sv */
// Self-checking testbench for sort_merge_key_counts_core: batches of key/count beats in,
// sorted and merged key totals out, each compared against a local software store.
// Depends on smkc_pkg and the RTL of sort_merge_key_counts_core.
`default_nettype none

module tb_sort_merge_key_counts_core;
  import smkc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 140;
  localparam int DRAIN_CYCLES   = 80;

  logic      clk;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  smkc_in_t  item = '0;
  logic      strobe;
  smkc_out_t result;

  // Beats waiting to be driven and key totals waiting to come out.
  smkc_in_t  pending_pairs[$];
  smkc_out_t expected_totals[$];

  // Local copy of the sorted store.
  logic [KEY_BITS-1:0]   store_keys   [CAPACITY];
  logic [COUNT_BITS-1:0] store_counts [CAPACITY];
  int                    store_fill = 0;
  logic                  store_dropped = 1'b0;

  int beats_taken  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  // Sender idle percentage per phase. The receiver cannot hold results off,
  // so its stall phases run with a steady sender.
  int idle_by_phase [4] = '{0, 73, 0, 29};

  sort_merge_key_counts_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_pair(logic [KEY_W-1:0] k, logic [COUNT_W-1:0] c, logic last);
    smkc_in_t p;
    p.key       = k;
    p.count     = c;
    p.batch_end = last;
    pending_pairs.push_back(p);
  endfunction

  // Merge one accepted beat into the store; on a batch end, queue the sorted totals.
  function automatic void reduce_pair(smkc_in_t p);
    logic [KEY_BITS-1:0]   k;
    logic [COUNT_BITS-1:0] c;
    logic [COUNT_BITS:0]   sum;
    smkc_out_t             r;
    int                    pos;
    k   = p.key[KEY_BITS-1:0];
    c   = p.count[COUNT_BITS-1:0];
    pos = 0;
    while (pos < store_fill && store_keys[pos] < k) pos++;
    if (pos < store_fill && store_keys[pos] == k) begin
      sum = {1'b0, store_counts[pos]} + c;
      store_counts[pos] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    end else if (store_fill >= CAPACITY) begin
      store_dropped = 1'b1;
    end else begin
      for (int i = store_fill; i > pos; i--) begin
        store_keys[i]   = store_keys[i-1];
        store_counts[i] = store_counts[i-1];
      end
      store_keys[pos]   = k;
      store_counts[pos] = c;
      store_fill++;
    end
    if (p.batch_end) begin
      for (int i = 0; i < store_fill; i++) begin
        r.out_key     = store_keys[i];
        r.out_count   = store_counts[i];
        r.final_entry = (i == store_fill - 1);
        r.overflow    = store_dropped;
        expected_totals.push_back(r);
      end
      store_fill    = 0;
      store_dropped = 1'b0;
    end
  endfunction

  // Stimulus: directed batches first, then random batches.
  initial begin
    logic [KEY_W-1:0] pool [4];
    logic [KEY_W-1:0] used [$];
    logic [KEY_W-1:0] k;
    logic [COUNT_W-1:0] c;
    int directed_n;
    int batch_no;
    int len;

    // Single-beat batches at the key and count extremes.
    add_pair('0, 8'd0, 1'b1);
    add_pair('1, 8'hFF, 1'b1);
    // Merge to saturation; the batch end lands on a stored key.
    add_pair(64'd5, 8'd200, 1'b0);
    add_pair(64'd5, 8'd100, 1'b0);
    add_pair(64'd3, 8'd1, 1'b0);
    add_pair(64'd5, 8'd7, 1'b1);
    // Out-of-order inserts at the front, back and middle of the store.
    add_pair(64'd10, 8'd1, 1'b0);
    add_pair(64'd7, 8'd2, 1'b0);
    add_pair(64'd9, 8'd3, 1'b0);
    add_pair('1, 8'd4, 1'b0);
    add_pair('0, 8'd5, 1'b0);
    add_pair(64'd8, 8'd6, 1'b1);
    // One key repeated, pinned at the count maximum.
    add_pair(64'd42, 8'hFF, 1'b0);
    add_pair(64'd42, 8'hFF, 1'b0);
    add_pair(64'd42, 8'd0, 1'b1);
    // Zero counts and two keys on either side of the top-bit boundary.
    add_pair(64'd1, 8'd0, 1'b0);
    add_pair(64'd2, 8'd0, 1'b0);
    add_pair(64'd1, 8'd1, 1'b1);
    add_pair(64'h8000_0000_0000_0000, 8'd128, 1'b0);
    add_pair(64'h7FFF_FFFF_FFFF_FFFF, 8'd127, 1'b1);
    directed_n = pending_pairs.size();

    batch_no = 0;
    while (pending_pairs.size() < directed_n + RANDOM_BEATS) begin
      if (batch_no == 1 || batch_no == 6) begin
        // Fill the store exactly; the second time, go past capacity as well.
        used.delete();
        for (int j = 0; j < CAPACITY; j++) begin
          k = rand_key();
          used.push_back(k);
          add_pair(k, 8'($urandom), (batch_no == 1 && j == CAPACITY - 1));
        end
        if (batch_no == 6) begin
          for (int j = 0; j < 6; j++) begin
            k = (j % 2) ? used[$urandom_range(CAPACITY - 1)] : rand_key();
            add_pair(k, 8'($urandom), 1'b0);
          end
          // The final beat carries a new key, which is dropped.
          add_pair(rand_key(), 8'($urandom), 1'b1);
        end
      end else begin
        // Short batch drawing on a small key pool so that merges are common.
        for (int p = 0; p < 4; p++) begin
          case ($urandom_range(7))
            0: pool[p] = '0;
            1: pool[p] = '1;
            2: pool[p] = KEY_W'($urandom_range(15));
            default: pool[p] = rand_key();
          endcase
        end
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          k = ($urandom_range(99) < 60) ? pool[$urandom_range(3)] : rand_key();
          c = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 200)) : 8'($urandom);
          add_pair(k, c, (j == len - 1));
        end
      end
      batch_no++;
    end
  end

  // Reset.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: present the next beat after an accept or an idle cycle.
  always @(posedge clk) begin
    int idle_pct;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reduce_pair(item);
        beats_taken++;
      end
      if (!start || !busy) begin
        idle_pct = idle_by_phase[(beats_taken / 40) % 4];
        if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          item  <= pending_pairs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expected total.
  always @(posedge clk) begin
    smkc_out_t want;
    if (!rst && strobe) begin
      if (expected_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: key %h count %0d final %b overflow %b",
                   result.out_key, result.out_count, result.final_entry, result.overflow);
      end else begin
        want = expected_totals.pop_front();
        if (result.out_key !== want.out_key || result.out_count !== want.out_count ||
            result.final_entry !== want.final_entry || result.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected key %h count %0d final %b overflow %b,",
                      " got key %h count %0d final %b overflow %b"},
                     want.out_key, want.out_count, want.final_entry, want.overflow,
                     result.out_key, result.out_count, result.final_entry, result.overflow);
        end
      end
    end
  end

  // Watchdog: end the run if no expected beat moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || (strobe && expected_totals.size() != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of test: everything sent, every total received, then a short drain.
  initial begin
    @(negedge clk);
    while (rst || start || pending_pairs.size() != 0) @(negedge clk);
    while (expected_totals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_totals.size() != 0)
      $display("%0d expected result beats never arrived", expected_totals.size());
    if (mismatches == 0 && expected_totals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
